/* design/lpp_pkg.sv */
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the length-prefixed packet parser.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int MAX_PAYLOAD  = 8;
    localparam int IDX_W        = $clog2(MAX_PAYLOAD);
    localparam int CNT_W        = 4;
    localparam int PAYLOAD_W    = 64;

    localparam logic [7:0] HEADER_RESET  = 8'h55;
    localparam logic [7:0] TIMEOUT_RESET = 8'd19;
    localparam logic [7:0] IDLE_MAX      = 8'hFF;

    // configuration register indexes
    localparam logic [7:0] CFG_HEADER  = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT = 8'd1;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_CSUM    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_LENERR  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_SUM  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_status                status;
        logic [CNT_W-1:0]       length;
        logic [PAYLOAD_W-1:0]   payload;
    } t_result;

endpackage

/* design/lpp_core.sv */
// ----------------------------------------------------------------------------
// lpp_core
// Parser state, payload buffer, config registers and per-word result logic.
// ----------------------------------------------------------------------------
module lpp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpp_pkg::t_cfg_wr i_cfg,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output lpp_pkg::t_result o_result
);

    lpp_pkg::t_phase                r_phase, n_phase;
    logic [lpp_pkg::CNT_W-1:0]      r_exp_len, n_exp_len;
    logic [lpp_pkg::CNT_W-1:0]      r_count, n_count;
    logic [7:0]                     r_sum, n_sum;
    logic [7:0]                     r_idle, n_idle;
    logic [7:0]                     r_header;
    logic [7:0]                     r_timeout;
    logic [7:0]                     r_store [lpp_pkg::MAX_PAYLOAD];

    logic [lpp_pkg::CNT_W-1:0]      count_inc;
    logic                           store_we;
    logic                           non_finish;
    logic [lpp_pkg::PAYLOAD_W-1:0]  packed_payload;

    assign count_inc = r_count + lpp_pkg::CNT_W'(1);

    // mask out bytes past the packet length
    always_comb begin
        packed_payload = '0;
        for (int i = 0; i < lpp_pkg::MAX_PAYLOAD; i++) begin
            if (lpp_pkg::CNT_W'(i) < r_exp_len) begin
                packed_payload[8*i +: 8] = r_store[i];
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_exp_len  = r_exp_len;
        n_count    = r_count;
        n_sum      = r_sum;
        n_idle     = r_idle;
        store_we   = 1'b0;
        non_finish = 1'b1;
        o_result.status  = lpp_pkg::ST_BUSY;
        o_result.length  = '0;
        o_result.payload = '0;

        unique case (r_phase)
            lpp_pkg::PH_HUNT: begin
                if (i_byte == r_header) begin
                    n_phase = lpp_pkg::PH_LEN;
                end
            end
            lpp_pkg::PH_LEN: begin
                if (i_byte == 8'd0 || i_byte > 8'(lpp_pkg::MAX_PAYLOAD)) begin
                    non_finish      = 1'b0;
                    n_phase         = lpp_pkg::PH_HUNT;
                    n_count         = '0;
                    n_sum           = '0;
                    n_idle          = '0;
                    o_result.status = lpp_pkg::ST_LENERR;
                end else begin
                    n_exp_len = i_byte[lpp_pkg::CNT_W-1:0];
                    n_count   = '0;
                    n_sum     = '0;
                    n_phase   = lpp_pkg::PH_DATA;
                end
            end
            lpp_pkg::PH_DATA: begin
                store_we = 1'b1;
                n_sum    = r_sum + i_byte;
                n_count  = count_inc;
                if (count_inc >= r_exp_len) begin
                    n_phase = lpp_pkg::PH_SUM;
                end
            end
            lpp_pkg::PH_SUM: begin
                non_finish = 1'b0;
                if (i_byte == r_sum) begin
                    o_result.status  = lpp_pkg::ST_GOOD;
                    o_result.length  = r_exp_len;
                    o_result.payload = packed_payload;
                end else begin
                    o_result.status = lpp_pkg::ST_CSUM;
                end
                n_phase = lpp_pkg::PH_HUNT;
                n_count = '0;
                n_sum   = '0;
                n_idle  = '0;
            end
            default: begin
                n_phase = lpp_pkg::PH_HUNT;
            end
        endcase

        // idle counter check uses the count before this word
        if (non_finish) begin
            if (r_idle > r_timeout) begin
                n_phase         = lpp_pkg::PH_HUNT;
                n_count         = '0;
                n_sum           = '0;
                n_idle          = '0;
                o_result.status = lpp_pkg::ST_TIMEOUT;
            end else if (r_idle < lpp_pkg::IDLE_MAX) begin
                n_idle = r_idle + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lpp_pkg::PH_HUNT;
            r_exp_len <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_idle    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_idle    <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= lpp_pkg::HEADER_RESET;
            r_timeout <= lpp_pkg::TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lpp_pkg::CFG_HEADER:  r_header  <= i_cfg.data;
                lpp_pkg::CFG_TIMEOUT: r_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_count[lpp_pkg::IDX_W-1:0]] <= i_byte;
        end
    end

endmodule

/* design/lpp_out_reg.sv */
// ----------------------------------------------------------------------------
// lpp_out_reg
// Result register holding one word until the downstream side takes it.
// ----------------------------------------------------------------------------
module lpp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lpp_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output lpp_pkg::t_result o_result
);

    logic             r_valid;
    lpp_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/length_prefixed_packet_parser.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_parser
// Header / length / payload / checksum parser, one result word per byte.
// An accepted byte passes through the input register, then the result register.
// Throughput: 1 byte per cycle while the output is not stalled; parser state advances per step.
// Reset: synchronous active low; hunts for header, config back to defaults.
// Payload buffer is not cleared; only bytes of the current packet are read.
// ----------------------------------------------------------------------------
module length_prefixed_packet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_payload_length,
    output logic [63:0] o_payload,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             step;
    lpp_pkg::t_cfg_wr cfg;
    lpp_pkg::t_result core_result;
    lpp_pkg::t_result out_result;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // word moves into the result register when that register is free
    assign step    = r_in_valid && (!o_valid || !i_stall);
    assign o_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    lpp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (core_result)
    );

    lpp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_status         = out_result.status;
    assign o_payload_length = out_result.length;
    assign o_payload        = out_result.payload;

    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lpp_pkg::ST_GOOD) |->
        (o_payload_length != 4'd0 && o_payload_length <= 4'(lpp_pkg::MAX_PAYLOAD)))
        else $error("good packet with bad length");

    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lpp_pkg::ST_GOOD) |->
        (o_payload_length == 4'd0 && o_payload == 64'd0))
        else $error("non-good result carries payload");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_valid && i_stall) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending word lost while output stalled");

endmodule
